// ===== rtl/wconv3_pkg.sv =====
`default_nettype none

package wconv3_pkg;

  // pixel and coefficient formats
  localparam int PIX_W    = 8;
  localparam int COEF_W   = 8;
  localparam int KERN_N   = 3;
  localparam int PROD_W   = 17;
  localparam int ROWSUM_W = 19;
  localparam int SUM_W    = 20;
  localparam int MAG_W    = 19;
  localparam int MAG_MAX  = 293760;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int COEF_ROW_W = 24;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  // line store control from the pipeline
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lb_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/window_convolution_3x3_abs.sv =====
// a result passes the line store read, window, product and row sum stages and the output register
// throughput: one pixel per clock unless the output stalls, set by one read and one write per line store per cycle
// the whole five-stage pipeline holds while a result waits on m_tready
// reset: position, pipeline valids and window clear, coefficients go to zero,
// width 640 and height 480; the line stores are not cleared and need no sweep
`default_nettype none

module window_convolution_3x3_abs
  import wconv3_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // pixel input
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] pixel
  input  wire logic [0:0]            s_tuser,   // [0] frame_start
  // result output
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [23:0]                m_tdata,   // [18:0] magnitude, upper bits zero
  output logic                       m_tlast,   // row_end
  output logic [0:0]                 m_tuser,   // [0] frame_end
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int WW = $clog2(MAX_LINE + 1);

  // configuration
  logic [COEF_ROW_W-1:0] coef_row [KERN_N];
  logic [FW_W-1:0]       frame_width;
  logic [FH_W-1:0]       frame_height;
  logic [WW-1:0]         w_eff;
  logic [FH_W-1:0]       h_eff;

  // position
  logic [CW-1:0]   column_position;
  logic [FH_W-1:0] row_position;
  logic [CW-1:0]   col0;
  logic [FH_W-1:0] row0;
  logic            last_col;
  logic            last_row;
  logic            ok0;
  logic            adv;
  logic            acc;

  // stage 1: line store read
  logic             v1;
  logic [PIX_W-1:0] px1;
  logic [CW-1:0]    col1;
  logic             ok1;
  logic             rend1;
  logic             fend1;
  logic [PIX_W-1:0] up_col;
  logic [PIX_W-1:0] mid_col;
  lb_ctrl_t         lb_ctrl;

  // stage 2: window
  logic [PIX_W-1:0] window_pixels [KERN_N*KERN_N];
  logic             v2;
  logic             rend2;
  logic             fend2;

  // stage 3: products
  logic signed [PROD_W-1:0] prod_next [KERN_N*KERN_N];
  logic signed [PROD_W-1:0] prod      [KERN_N*KERN_N];
  logic                     v3;
  logic                     rend3;
  logic                     fend3;

  // stage 4: row sums
  logic signed [ROWSUM_W-1:0] row_sum_next [KERN_N];
  logic signed [ROWSUM_W-1:0] row_sum      [KERN_N];
  logic                       v4;
  logic                       rend4;
  logic                       fend4;

  logic signed [SUM_W-1:0] total;
  logic [MAG_W-1:0]        mag_next;
  logic [MAG_W-1:0]        magnitude;

  // handshake, nothing is taken while in reset
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv && !rst;
  assign acc       = s_tvalid && s_tready;
  assign cfg_ready = !rst;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < KERN_N; r++) begin
        coef_row[r] <= '0;
      end
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEF_ROW0:    coef_row[0]  <= cfg_data[COEF_ROW_W-1:0];
        REG_COEF_ROW1:    coef_row[1]  <= cfg_data[COEF_ROW_W-1:0];
        REG_COEF_ROW2:    coef_row[2]  <= cfg_data[COEF_ROW_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (32'(frame_width) < 32'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(frame_width) > 32'(MAX_LINE)) begin
      w_eff = WW'(MAX_LINE);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (32'(frame_height) < 32'(MIN_DIM)) begin
      h_eff = FH_W'(MIN_DIM);
    end else begin
      h_eff = frame_height;
    end
  end

  // current position and border flags
  always_comb begin
    col0     = s_tuser[0] ? '0 : column_position;
    row0     = s_tuser[0] ? '0 : row_position;
    last_col = (WW'(col0) + WW'(1)) >= w_eff;
    last_row = ((FH_W+1)'(row0) + (FH_W+1)'(1)) >= (FH_W+1)'(h_eff);
    ok0      = (row0 >= FH_W'(2)) && (col0 >= CW'(2));
  end

  // position advance
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (acc) begin
      if (last_col) begin
        column_position <= '0;
        row_position    <= last_row ? '0 : row0 + FH_W'(1);
      end else begin
        column_position <= col0 + CW'(1);
        row_position    <= row0;
      end
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1   <= s_tdata[PIX_W-1:0];
      col1  <= col0;
      ok1   <= ok0;
      rend1 <= last_col;
      fend1 <= last_col && last_row;
    end
  end

  assign lb_ctrl.rd_en = adv;
  assign lb_ctrl.wr_en = adv && v1;

  wconv3_line_buf #(
    .MAX_LINE (MAX_LINE)
  ) u_line_buf (
    .clk      (clk),
    .ctrl     (lb_ctrl),
    .rd_addr  (col0),
    .wr_addr  (col1),
    .wr_pixel (px1),
    .up_col   (up_col),
    .mid_col  (mid_col)
  );

  // window shift, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KERN_N*KERN_N; i++) begin
        window_pixels[i] <= '0;
      end
    end else if (adv && v1) begin
      for (int r = 0; r < KERN_N; r++) begin
        window_pixels[r*KERN_N]     <= window_pixels[r*KERN_N + 1];
        window_pixels[r*KERN_N + 1] <= window_pixels[r*KERN_N + 2];
      end
      window_pixels[2] <= up_col;
      window_pixels[5] <= mid_col;
      window_pixels[8] <= px1;
    end
  end

  // nine coefficient products
  always_comb begin
    for (int r = 0; r < KERN_N; r++) begin
      for (int c = 0; c < KERN_N; c++) begin
        prod_next[r*KERN_N + c] =
          $signed(coef_row[r][COEF_W*c +: COEF_W]) * $signed({1'b0, window_pixels[r*KERN_N + c]});
      end
    end
  end

  // row sums
  always_comb begin
    for (int r = 0; r < KERN_N; r++) begin
      row_sum_next[r] = ROWSUM_W'(prod[r*KERN_N]) + ROWSUM_W'(prod[r*KERN_N + 1])
                      + ROWSUM_W'(prod[r*KERN_N + 2]);
    end
  end

  // final sum and absolute value
  always_comb begin
    total    = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
    mag_next = total[SUM_W-1] ? MAG_W'(-total) : MAG_W'(total);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v2       <= v1 && ok1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      rend2     <= rend1;
      fend2     <= fend1;
      prod      <= prod_next;
      rend3     <= rend2;
      fend3     <= fend2;
      row_sum   <= row_sum_next;
      rend4     <= rend3;
      fend4     <= fend3;
      magnitude <= mag_next;
      m_tlast   <= rend4;
      m_tuser   <= fend4;
    end
  end

  assign m_tdata = {(24-MAG_W)'(0), magnitude};

  // a frame end is always a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("frame end without row end");

  // magnitude stays within the kernel bound
  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[MAG_W-1:0]) <= 32'(MAG_MAX)))
    else $error("magnitude out of range");

  // frame start puts the next pixel at row 0, column 1
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    acc && s_tuser[0] |=> (column_position == CW'(1)) && (row_position == '0))
    else $error("frame start position wrong");

  // a new result only comes out of the last stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v4))
    else $error("result without a pipeline item");

endmodule

`default_nettype wire

// ===== rtl/wconv3_line_buf.sv =====
`default_nettype none

module wconv3_line_buf
  import wconv3_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  wire logic                        clk,
  input  wire lb_ctrl_t                    ctrl,
  input  wire logic [$clog2(MAX_LINE)-1:0] rd_addr,
  input  wire logic [$clog2(MAX_LINE)-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]            wr_pixel,
  output logic      [PIX_W-1:0]            up_col,
  output logic      [PIX_W-1:0]            mid_col
);

  localparam int CW = $clog2(MAX_LINE);

  logic [PIX_W-1:0] upper_line  [MAX_LINE];
  logic [PIX_W-1:0] middle_line [MAX_LINE];

  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;
  logic             byp;
  logic [PIX_W-1:0] byp_up;
  logic [PIX_W-1:0] byp_mid;
  logic [CW-1:0]    addr_q;

  // effective column data for the item in the read stage
  assign up_col  = byp ? byp_up  : up_rd;
  assign mid_col = byp ? byp_mid : mid_rd;

  // registered reads
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      up_rd  <= upper_line[rd_addr];
      mid_rd <= middle_line[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // column rotation: middle moves up, new pixel goes to middle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      upper_line[wr_addr]  <= mid_col;
      middle_line[wr_addr] <= wr_pixel;
    end
  end

  // forward a write still pending on the same column
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      byp     <= ctrl.wr_en && (rd_addr == wr_addr);
      byp_up  <= mid_col;
      byp_mid <= wr_pixel;
    end
  end

  // a forwarded read must come from the column written on that edge
  a_byp_addr: assert property (@(posedge clk)
    ctrl.rd_en && ctrl.wr_en && (rd_addr == wr_addr) |=> byp && (addr_q == $past(wr_addr)))
    else $error("line store forward lost");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import wconv3_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int TDATA_W    = 24;
  localparam int DRAIN_WAIT = 8;

  // one pixel request and one expected result
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_req_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             row_end;
    logic             frame_end;
  } conv_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] pixel
  logic [0:0]            s_tuser = '0;   // [0] frame_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;        // [18:0] magnitude
  logic                  m_tlast;        // row_end
  logic [0:0]            m_tuser;        // [0] frame_end
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  window_convolution_3x3_abs #(
    .MAX_LINE (LINE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // pending pixels, expected magnitudes, error count
  pixel_req_t   pixel_q[$];
  conv_result_t pending_magnitudes[$];
  int           error_count = 0;
  bit           s_busy = 1'b0;
  pixel_req_t   send_item;
  int           send_gap = 0;
  int           stall_left = 0;
  int           send_pct = 0;
  int           stall_pct = 0;

  // predictor copy of registers and datapath state
  logic [COEF_ROW_W-1:0] coef_reg [3];
  logic [FW_W-1:0]       width_reg;
  logic [FH_W-1:0]       height_reg;
  logic [PIX_W-1:0]      upper_store [LINE_DEPTH];
  logic [PIX_W-1:0]      middle_store [LINE_DEPTH];
  logic [PIX_W-1:0]      win [9];
  int                    col_pos;
  int                    row_pos;

  initial begin
    coef_reg[0] = '0;
    coef_reg[1] = '0;
    coef_reg[2] = '0;
    width_reg   = FW_RESET;
    height_reg  = FH_RESET;
    for (int k = 0; k < 9; k++) win[k] = '0;
    col_pos = 0;
    row_pos = 0;
  end

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // hard stop
  initial begin
    #(4_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int eff_width(input logic [FW_W-1:0] raw);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > LINE_DEPTH) return LINE_DEPTH;
    return int'(raw);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_COEF_ROW0:    coef_reg[0] = val[COEF_ROW_W-1:0];
      REG_COEF_ROW1:    coef_reg[1] = val[COEF_ROW_W-1:0];
      REG_COEF_ROW2:    coef_reg[2] = val[COEF_ROW_W-1:0];
      REG_FRAME_WIDTH:  width_reg = val[FW_W-1:0];
      REG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
      default: ;
    endcase
  endfunction

  // shift the window, update line stores, return 1 with the magnitude on interior windows
  function automatic bit convolve_pixel(input logic [PIX_W-1:0] px, input logic fs,
                                        output conv_result_t res);
    int w, h, col, row, acc, mag, r, c;
    bit last_col, last_row;
    logic signed [COEF_W-1:0] k;
    w = eff_width(width_reg);
    h = (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos % LINE_DEPTH;
    row = row_pos;
    for (r = 0; r < 3; r++) begin
      win[3*r]   = win[3*r+1];
      win[3*r+1] = win[3*r+2];
    end
    win[2] = upper_store[col];
    win[5] = middle_store[col];
    win[8] = px;
    upper_store[col]  = middle_store[col];
    middle_store[col] = px;
    last_col = (col + 1) >= w;
    last_row = (row + 1) >= h;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    res = '0;
    if (row < 2 || col < 2) return 1'b0;
    acc = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        k = coef_reg[r][8*c +: 8];
        acc += int'(k) * int'(win[3*r+c]);
      end
    end
    mag = (acc < 0) ? -acc : acc;
    res.magnitude = mag[MAG_W-1:0];
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    return 1'b1;
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0 && send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
        send_gap = $urandom_range(1, 19) - 1;
        s_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        send_item = pixel_q.pop_front();
        s_tdata  <= send_item.pixel;
        s_tuser  <= send_item.frame_start;
        s_tvalid <= 1'b1;
        s_busy = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with stall bursts
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: check results, predict from accepted pixels
  always @(posedge clk) begin : monitor
    conv_result_t want, pred;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_magnitudes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got magnitude %0d row_end %0b frame_end %0b",
                   $time, m_tdata, m_tlast, m_tuser[0]);
          error_count++;
        end else begin
          want = pending_magnitudes.pop_front();
          if (m_tdata !== {{(TDATA_W-MAG_W){1'b0}}, want.magnitude}) begin
            $display("%0t: magnitude expected %0d got %0d", $time, want.magnitude, m_tdata);
            error_count++;
          end
          if (m_tlast !== want.row_end) begin
            $display("%0t: row_end expected %0b got %0b", $time, want.row_end, m_tlast);
            error_count++;
          end
          if (m_tuser[0] !== want.frame_end) begin
            $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end, m_tuser[0]);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        s_busy = 1'b0;
        if (convolve_pixel(s_tdata, s_tuser[0], pred)) begin
          pending_magnitudes = {pending_magnitudes, pred};
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
    pixel_req_t item;
    item.pixel = px;
    item.frame_start = fs;
    pixel_q = {pixel_q, item};
  endtask

  // random raster pixels, a few stray frame starts as noise
  task automatic push_frame_pixels(input int count, input bit restart);
    logic [PIX_W-1:0] px;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else px = PIX_W'($urandom_range(0, 255));
      push_pixel(px, (i == 0 && restart) || ($urandom_range(0, 99) < 2));
    end
  endtask

  // wait until every request is taken and every result has come, then let the pipe empty
  task automatic drain();
    @(negedge clk);
    while (pixel_q.size() > 0 || s_busy || pending_magnitudes.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [COEF_ROW_W-1:0] rand_coef_row();
    logic [COEF_ROW_W-1:0] v;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 7))
        0: v[8*j +: 8] = 8'h80;
        1: v[8*j +: 8] = 8'h7F;
        2: v[8*j +: 8] = 8'hFF;
        default: v[8*j +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  // stimulus
  initial begin : stimulus
    int n, cur_w;
    bit restart;
    logic [CFG_DATA_W-1:0] w_raw, h_raw;
    wait (!rst);
    send_pct  = 20;
    stall_pct = 5;

    // largest magnitude with all coefficients at -128, then a zero image by frame wrap
    write_reg(REG_COEF_ROW0, 24'h808080);
    write_reg(REG_COEF_ROW1, 24'h808080);
    write_reg(REG_COEF_ROW2, 24'h808080);
    write_reg(REG_FRAME_WIDTH, 24'd0);
    write_reg(REG_FRAME_HEIGHT, 24'd0);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);
    for (int i = 0; i < 9; i++) push_pixel(8'h00, 1'b0);
    drain();

    // mixed-sign kernel, frame start on the last column of a row
    write_reg(REG_COEF_ROW0, 24'h7F0180);
    write_reg(REG_COEF_ROW1, 24'h00FF7F);
    write_reg(REG_COEF_ROW2, 24'h7F7F7F);
    write_reg(REG_FRAME_WIDTH, 24'd2);
    write_reg(REG_FRAME_HEIGHT, 24'd2);
    push_pixel(8'h5A, 1'b0);
    push_pixel(8'hA5, 1'b0);
    for (int i = 0; i < 9; i++) push_pixel((i % 2) ? 8'h00 : 8'hFF, i == 0);
    drain();
    cur_w = eff_width(width_reg);

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      n = $urandom_range(40, 60);
      case (ph)
        0: begin w_raw = 24'd3; h_raw = 24'd3; end
        1: begin w_raw = 24'd4; h_raw = 24'hFFFF; end
        3: begin w_raw = 24'h7FF; h_raw = 24'd3; end
        default: begin
          w_raw = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                              : CFG_DATA_W'($urandom_range(3, 20));
          h_raw = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                              : CFG_DATA_W'($urandom_range(3, 10));
        end
      endcase
      case ($urandom_range(0, 3))
        0: send_pct = 0;
        1: send_pct = 5;
        2: send_pct = 15;
        default: send_pct = 35;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 3;
        2: stall_pct = 8;
        default: stall_pct = 20;
      endcase
      if (ph == 11) begin
        send_pct   = 0;
        stall_pct  = 0;
        send_gap   = 0;
        stall_left = 0;
      end
      write_reg(REG_COEF_ROW0, rand_coef_row());
      write_reg(REG_COEF_ROW1, rand_coef_row());
      write_reg(REG_COEF_ROW2, rand_coef_row());
      write_reg(REG_FRAME_WIDTH, w_raw);
      write_reg(REG_FRAME_HEIGHT, h_raw);
      // a wider row needs a fresh frame so no window reads columns never written
      restart = (ph == 0) || (eff_width(width_reg) > cur_w) || $urandom_range(0, 1);
      cur_w = eff_width(width_reg);
      if (ph == 2) begin
        push_frame_pixels(n / 2, restart);
        drain();
        push_frame_pixels(n - n / 2, 1'b0);
      end else begin
        push_frame_pixels(n, restart);
      end
      drain();
    end

    repeat (12) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wconv3_pkg.sv
rtl/wconv3_line_buf.sv
rtl/window_convolution_3x3_abs.sv
tb/tb.sv
